// ===== rtl/eol_pkg.sv =====
// ----------------------------------------------------------------------------
// eol_pkg - envelope overshoot limiter shared definitions
// register indexes, fixed field widths and divisor format
// ----------------------------------------------------------------------------
package eol_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register field widths
  localparam int GAIN_W = 16;
  localparam int WLEN_W = 6;

  // divisor: 1.0 sits at bit FRAC_BITS, scaled gain product fits SCALED_W bits
  localparam int FRAC_BITS = 28;
  localparam int SCALED_W  = 32;
  localparam int DEN_W     = 33;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/eol_ram.sv =====
// ----------------------------------------------------------------------------
// eol_ram - generic single write, single read RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module eol_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/envelope_overshoot_limiter.sv =====
// ----------------------------------------------------------------------------
// envelope_overshoot_limiter - controlled envelope overshoot limiter
// delays I/Q samples by half a window and divides them down when the peak
// envelope over the window exceeds 1.0
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_wdata            | in
//  in      | in_valid, in_stall, in_i, in_q          | in
//  out     | out_valid, out_stall, out_i, out_q      | out
//
//  enabled: a request runs through the bit-serial squarer, square root and
//    divider before the next accept; a window rescan adds a pass over the
//    window entries, one RAM read a cycle
//  disabled: the sample passes straight through, skipping the arithmetic
//  reset clears the valid bits of the delay line at once, no clearing pass
//  a result waits in the output register while the next request is taken;
//    the block only stalls at its final step if that register is still full
//
module envelope_overshoot_limiter #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [eol_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eol_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input samples
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_q,
  // output samples
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_i,
  output logic signed [SAMPLE_BITS-1:0]       out_q
);

  // --------------------------------------------------------------------------
  // derived sizes
  // --------------------------------------------------------------------------
  localparam int S       = SAMPLE_BITS;
  localparam int AW      = $clog2(MAX_WINDOW);
  // largest odd window that fits the delay line
  localparam int LIM     = (((MAX_WINDOW - 1) % 2) == 1) ? MAX_WINDOW - 1 : MAX_WINDOW - 2;
  localparam int CNT_MAX = (S > eol_pkg::GAIN_W) ? S : eol_pkg::GAIN_W;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam int SQ_W    = 2 * S;
  localparam int RAM_W   = 3 * S;
  localparam int NUM_W   = S + eol_pkg::FRAC_BITS;
  localparam int PROD_W  = eol_pkg::GAIN_W + S;
  // gain * (peak - 1.0) is in units of 2^-(S+12); bring it to 2^-28
  localparam int LSH     = (S <= eol_pkg::GAIN_W) ? eol_pkg::GAIN_W - S : 0;
  localparam int RSH     = (S > eol_pkg::GAIN_W) ? S - eol_pkg::GAIN_W : 0;
  localparam int PX_W    = PROD_W + LSH;
  localparam int DEN_W   = eol_pkg::DEN_W;

  localparam logic [S-1:0] ONE_ENV = {2'b01, {(S-2){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_WR,
    ST_SCAN,
    ST_MUL,
    ST_DEN,
    ST_DIV,
    ST_DONE
  } state_t;

  // effective odd window: at least 3, at most the delay line allows
  function automatic logic [AW-1:0] eff_window(input logic [eol_pkg::WLEN_W-1:0] wl);
    int p;
    p = int'(wl) | 1;
    if (p < 3) p = 3;
    if (p > LIM) p = LIM;
    return AW'(p);
  endfunction

  function automatic logic [S-1:0] mag_of(input logic [S-1:0] x);
    return x[S-1] ? ((~x) + S'(1)) : x;
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t                      state_r;
  logic                        enable_r;
  logic [eol_pkg::GAIN_W-1:0]  gain_r;
  logic [eol_pkg::WLEN_W-1:0]  wlen_r;
  logic [AW-1:0]               wr_idx_r;
  logic [AW-1:0]               rd_idx_r;
  logic [MAX_WINDOW-1:0]       vld_r;
  logic [S-1:0]                peak_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        pass_r;
  logic [AW-1:0]               scan_idx_r;
  logic                        scan_pend_r;
  logic                        rd_vld_r;
  logic                        out_valid_r;

  // datapath, no reset
  logic [S-1:0]                raw_i_r, raw_q_r;
  logic [S-1:0]                sbi_r, sbq_r;       // multiplier bits, msb first
  logic [SQ_W-1:0]             acc_r;              // i^2 + q^2, then root operand
  logic [S+1:0]                rem_r;
  logic [S-1:0]                root_r;
  logic [S-1:0]                evict_r;
  logic [S-1:0]                samp_i_r, samp_q_r;
  logic [eol_pkg::GAIN_W-1:0]  gbit_r;
  logic [PROD_W-1:0]           prod_r;
  logic [DEN_W-1:0]            den_r;
  logic [DEN_W-1:0]            drem_i_r, drem_q_r;
  logic [S-1:0]                dlow_i_r, dlow_q_r;
  logic [S-1:0]                quo_i_r, quo_q_r;
  logic [S-1:0]                out_i_r, out_q_r;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic                        in_acc;
  logic                        out_free;
  logic [AW-1:0]               win;
  logic [AW-1:0]               half;
  logic [AW-1:0]               wr_idx_nxt, rd_idx_nxt;
  logic [AW-1:0]               raddr;
  logic [RAM_W-1:0]            rdata;
  logic [S-1:0]                rd_env;
  logic [S-1:0]                mi, mq;
  logic [SQ_W-1:0]             acc_nxt;
  logic [S+1:0]                rem_try, root_trial;
  logic                        root_ge;
  logic [S-1:0]                pk_nxt;
  logic                        rescan;
  logic                        scan_end;
  logic [S-1:0]                dlt;
  logic [PROD_W-1:0]           prod_nxt;
  logic [PX_W-1:0]             prod_ext;
  logic [PX_W-1:0]             prod_sh;
  logic [DEN_W-1:0]            den_nxt;
  logic [S-1:0]                smag_i, smag_q;
  logic [NUM_W-1:0]            num_i, num_q;
  logic [DEN_W:0]              dtry_i, dtry_q;
  logic                        dge_i, dge_q;
  logic [S-1:0]                sres_i, sres_q;
  logic [eol_pkg::WLEN_W-1:0]  clr_wlen;
  logic                        cfg_clear;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign win  = eff_window(wlen_r);
  assign half = win >> 1;

  // both indices walk downward modulo the window
  assign wr_idx_nxt = (wr_idx_r == '0) ? win - AW'(1) : wr_idx_r - AW'(1);
  assign rd_idx_nxt = (rd_idx_r == '0) ? win - AW'(1) : rd_idx_r - AW'(1);

  // read port: evicted entry at accept, delayed sample during squaring,
  // window entries during a rescan
  always_comb begin
    case (state_r)
      ST_IDLE: raddr = wr_idx_r;
      ST_SQR:  raddr = rd_idx_r;
      ST_SCAN: raddr = scan_idx_r;
      default: raddr = wr_idx_r;
    endcase
  end

  // entries never written since the last clear read as zero
  assign rd_env = rd_vld_r ? rdata[S-1:0] : '0;

  // squarer: msb-first shift-add of both magnitudes into one accumulator
  assign mi = mag_of(raw_i_r);
  assign mq = mag_of(raw_q_r);
  assign acc_nxt = {acc_r[SQ_W-2:0], 1'b0}
                 + (sbi_r[S-1] ? SQ_W'(mi) : '0)
                 + (sbq_r[S-1] ? SQ_W'(mq) : '0);

  // square root, two operand bits per cycle
  assign rem_try    = {rem_r[S-1:0], acc_r[SQ_W-1:SQ_W-2]};
  assign root_trial = {root_r, 2'b01};
  assign root_ge    = (rem_try >= root_trial);

  // peak update and rescan decision
  assign pk_nxt = (root_r > peak_r) ? root_r : peak_r;
  assign rescan = (evict_r >= pk_nxt) && (evict_r != '0);

  assign scan_end = (scan_idx_r == win) && !scan_pend_r;

  // divisor: 1.0 + gain * (peak - 1.0) when the peak exceeds 1.0
  assign dlt      = (peak_r > ONE_ENV) ? peak_r - ONE_ENV : '0;
  assign prod_nxt = {prod_r[PROD_W-2:0], 1'b0}
                  + (gbit_r[eol_pkg::GAIN_W-1] ? PROD_W'(dlt) : '0);
  assign prod_ext = PX_W'(prod_r) << LSH;
  assign prod_sh  = prod_ext >> RSH;
  assign den_nxt  = (DEN_W'(1) << eol_pkg::FRAC_BITS)
                  + DEN_W'(prod_sh[eol_pkg::SCALED_W-1:0]);

  // restoring divider, one quotient bit per cycle on each lane
  assign smag_i = mag_of(samp_i_r);
  assign smag_q = mag_of(samp_q_r);
  assign num_i  = {smag_i, {eol_pkg::FRAC_BITS{1'b0}}};
  assign num_q  = {smag_q, {eol_pkg::FRAC_BITS{1'b0}}};
  assign dtry_i = {drem_i_r, dlow_i_r[S-1]};
  assign dtry_q = {drem_q_r, dlow_q_r[S-1]};
  assign dge_i  = (dtry_i >= {1'b0, den_r});
  assign dge_q  = (dtry_q >= {1'b0, den_r});

  // restore the sign, truncation toward zero comes for free
  assign sres_i = samp_i_r[S-1] ? ((~quo_i_r) + S'(1)) : quo_i_r;
  assign sres_q = samp_q_r[S-1] ? ((~quo_q_r) + S'(1)) : quo_q_r;

  // writing enable or window length restarts the delay line
  assign cfg_clear = cfg_we && ((cfg_index == eol_pkg::CFG_ENABLE) ||
                                (cfg_index == eol_pkg::CFG_WINDOW));
  assign clr_wlen  = (cfg_index == eol_pkg::CFG_WINDOW) ?
                     cfg_wdata[eol_pkg::WLEN_W-1:0] : wlen_r;

  // --------------------------------------------------------------------------
  // delay line: {i, q, envelope} per entry
  // --------------------------------------------------------------------------
  eol_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WINDOW)
  ) u_dly (
    .clk   (clk),
    .we    (state_r == ST_WR),
    .waddr (wr_idx_r),
    .wdata ({raw_i_r, raw_q_r, root_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // control: sequencer, indices, valid bits, peak, configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      gain_r      <= eol_pkg::GAIN_RESET;
      wlen_r      <= eol_pkg::WLEN_RESET;
      wr_idx_r    <= '0;
      rd_idx_r    <= eff_window(eol_pkg::WLEN_RESET) >> 1;
      vld_r       <= '0;
      peak_r      <= '0;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      scan_idx_r  <= '0;
      scan_pend_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pass_r <= !enable_r;
            cnt_r  <= CNT_W'(S - 1);
            state_r <= enable_r ? ST_SQR : ST_DONE;
          end
        end
        ST_SQR: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            cnt_r   <= CNT_W'(S - 1);
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          vld_r[wr_idx_r] <= 1'b1;
          wr_idx_r        <= wr_idx_nxt;
          rd_idx_r        <= rd_idx_nxt;
          cnt_r           <= CNT_W'(eol_pkg::GAIN_W - 1);
          if (rescan) begin
            peak_r      <= '0;
            scan_idx_r  <= '0;
            scan_pend_r <= 1'b0;
            state_r     <= ST_SCAN;
          end else begin
            peak_r  <= pk_nxt;
            state_r <= ST_MUL;
          end
        end
        ST_SCAN: begin
          // each read is compared in the cycle after it is issued
          scan_pend_r <= (scan_idx_r != win);
          if (scan_idx_r != win) begin
            scan_idx_r <= scan_idx_r + AW'(1);
          end
          if (scan_pend_r && (rd_env > peak_r)) begin
            peak_r <= rd_env;
          end
          if (scan_end) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          cnt_r   <= CNT_W'(S - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // configuration must only be written while idle; the block itself does not enforce this
      if (cfg_we) begin
        case (cfg_index)
          eol_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
          eol_pkg::CFG_GAIN:   gain_r   <= cfg_wdata[eol_pkg::GAIN_W-1:0];
          eol_pkg::CFG_WINDOW: wlen_r   <= cfg_wdata[eol_pkg::WLEN_W-1:0];
          default: ;
        endcase
      end
      if (cfg_clear) begin
        vld_r    <= '0;
        wr_idx_r <= '0;
        rd_idx_r <= eff_window(clr_wlen) >> 1;
        peak_r   <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath shift registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          raw_i_r <= in_i;
          raw_q_r <= in_q;
          sbi_r   <= mag_of(in_i);
          sbq_r   <= mag_of(in_q);
          acc_r   <= '0;
        end
      end
      ST_SQR: begin
        acc_r <= acc_nxt;
        sbi_r <= {sbi_r[S-2:0], 1'b0};
        sbq_r <= {sbq_r[S-2:0], 1'b0};
        // the evicted entry arrives first, then the delayed sample
        if (cnt_r == CNT_W'(S - 1)) begin
          evict_r <= rd_env;
        end
        if (cnt_r == CNT_W'(S - 2)) begin
          samp_i_r <= rd_vld_r ? rdata[RAM_W-1:2*S] : '0;
          samp_q_r <= rd_vld_r ? rdata[2*S-1:S] : '0;
        end
        if (cnt_r == '0) begin
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      ST_ROOT: begin
        acc_r  <= {acc_r[SQ_W-3:0], 2'b00};
        rem_r  <= root_ge ? rem_try - root_trial : rem_try;
        root_r <= {root_r[S-2:0], root_ge};
      end
      ST_WR: begin
        gbit_r <= gain_r;
        prod_r <= '0;
      end
      ST_MUL: begin
        prod_r <= prod_nxt;
        gbit_r <= {gbit_r[eol_pkg::GAIN_W-2:0], 1'b0};
      end
      ST_DEN: begin
        den_r    <= den_nxt;
        drem_i_r <= DEN_W'(num_i[NUM_W-1:S]);
        drem_q_r <= DEN_W'(num_q[NUM_W-1:S]);
        dlow_i_r <= num_i[S-1:0];
        dlow_q_r <= num_q[S-1:0];
      end
      ST_DIV: begin
        drem_i_r <= dge_i ? DEN_W'(dtry_i - {1'b0, den_r}) : dtry_i[DEN_W-1:0];
        drem_q_r <= dge_q ? DEN_W'(dtry_q - {1'b0, den_r}) : dtry_q[DEN_W-1:0];
        dlow_i_r <= {dlow_i_r[S-2:0], 1'b0};
        dlow_q_r <= {dlow_q_r[S-2:0], 1'b0};
        quo_i_r  <= {quo_i_r[S-2:0], dge_i};
        quo_q_r  <= {quo_q_r[S-2:0], dge_q};
      end
      ST_DONE: begin
        if (out_free) begin
          out_i_r <= pass_r ? raw_i_r : sres_i;
          out_q_r <= pass_r ? raw_q_r : sres_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic [AW:0] lag_sum;
  logic [AW:0] lag_exp;

  assign lag_sum = {1'b0, wr_idx_r} + {1'b0, half};
  assign lag_exp = (lag_sum >= {1'b0, win}) ? lag_sum - {1'b0, win} : lag_sum;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_idx_r < win) && (rd_idx_r < win))
    else $error("delay line index outside window");

  a_idx_lag: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r == lag_exp[AW-1:0])
    else $error("read index does not trail write index by half a window");

  a_scan_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && scan_end |-> (peak_r >= root_r))
    else $error("rescan peak below newest envelope");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == '0) |=> (quo_i_r <= smag_i) && (quo_q_r <= smag_q))
    else $error("scaled sample larger than input");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && out_stall |=> (state_r == ST_DONE))
    else $error("result finished while output register still full");

endmodule

// ===== tb/sv/envelope_overshoot_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// envelope_overshoot_limiter_tb - self-checking bench for the overshoot limiter
// a directed table followed by random sample streams over several register
// settings; every accepted request is run through a local limiter model and
// each output sample is compared field by field in arrival order
// ----------------------------------------------------------------------------
module envelope_overshoot_limiter_tb;
  import eol_pkg::*;

  localparam int MAX_WIN = 64;
  localparam int SMP_W   = 16;
  // 1.0 in envelope units and in the divisor scale
  localparam longint unsigned UNITY   = 64'd1 << (SMP_W - 2);
  localparam longint unsigned ONE_Q28 = 64'd1 << FRAC_BITS;
  // register index the block has no register behind
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SEGMENTS    = 15;
  localparam int SEG_ITEMS   = 95;
  localparam int DRAIN_TICKS = 80;

  typedef struct packed {
    logic signed [SMP_W-1:0] i;
    logic signed [SMP_W-1:0] q;
  } iq_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [SMP_W-1:0]       si;
    logic [SMP_W-1:0]       sq;
    bit                     known;
    iq_t                    want;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SMP_W-1:0]       in_i;
  logic signed [SMP_W-1:0]       in_q;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SMP_W-1:0]       out_i;
  logic signed [SMP_W-1:0]       out_q;

  envelope_overshoot_limiter #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_BITS (SMP_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_i      (in_i),
    .in_q      (in_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q)
  );

  // ---------------------------------------------------------------------------
  // limiter model: register copies, delay lines and running peak
  // ---------------------------------------------------------------------------
  bit                  run_en;
  logic [GAIN_W-1:0]   gain_reg;
  logic [WLEN_W-1:0]   wlen_reg;
  logic [SMP_W-1:0]    hist_i   [MAX_WIN];
  logic [SMP_W-1:0]    hist_q   [MAX_WIN];
  logic [SMP_W:0]      hist_env [MAX_WIN];
  int unsigned         wr_pos;
  int unsigned         rd_pos;
  logic [SMP_W:0]      win_peak;

  // output samples still owed by the block, oldest first
  iq_t due_iq[$];
  int  bad_count;

  // idle odds in percent, per cycle
  int unsigned snd_idle;
  int unsigned rcv_idle;

  plan_row_t plan[$];

  // window actually used: forced odd, at least 3, at most the largest odd
  // length that fits the delay lines
  function automatic int unsigned span_len();
    int unsigned p;
    int unsigned lim;
    p   = int'(wlen_reg) | 1;
    lim = MAX_WIN - 1;
    if (lim % 2 == 0) lim--;
    if (p < 3) p = 3;
    if (p > lim) p = lim;
    return p;
  endfunction

  function automatic void wipe_history();
    for (int k = 0; k < MAX_WIN; k++) begin
      hist_i[k]   = '0;
      hist_q[k]   = '0;
      hist_env[k] = '0;
    end
    wr_pos   = 0;
    rd_pos   = span_len() / 2;
    win_peak = '0;
  endfunction

  // enable and window writes flush the history, gain writes keep it
  function automatic void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE: begin
        run_en = data[0];
        wipe_history();
      end
      CFG_GAIN: begin
        gain_reg = data[GAIN_W-1:0];
      end
      CFG_WINDOW: begin
        wlen_reg = data[WLEN_W-1:0];
        wipe_history();
      end
      default: ;
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned b;
    rem = n;
    res = 0;
    b   = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag16(logic [SMP_W-1:0] v);
    longint signed x;
    x = longint'($signed(v));
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // sample times 2^28 over the divisor, truncated toward zero
  function automatic logic [SMP_W-1:0] shrink(logic [SMP_W-1:0] raw, longint unsigned den);
    longint unsigned m;
    m = (mag16(raw) << FRAC_BITS) / den;
    if (raw[SMP_W-1]) m = -m;
    return m[SMP_W-1:0];
  endfunction

  // one accepted request: update the window and return the delayed, scaled sample; pass it unchanged when disabled
  function automatic iq_t limit_sample(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq);
    int unsigned     p;
    int unsigned     w;
    int unsigned     r;
    longint unsigned env;
    longint unsigned old_env;
    longint unsigned den;
    iq_t             res;
    p = span_len();
    w = wr_pos % p;
    r = rd_pos % p;
    if (!run_en) begin
      res.i = si;
      res.q = sq;
      return res;
    end
    env = int_sqrt(mag16(si) * mag16(si) + mag16(sq) * mag16(sq));
    hist_i[w]   = si;
    hist_q[w]   = sq;
    old_env     = hist_env[w];
    hist_env[w] = env[SMP_W:0];
    if (env > win_peak) win_peak = env[SMP_W:0];
    // the peak just left the window: rescan what is left
    if (old_env >= win_peak && old_env > 0) begin
      win_peak = '0;
      for (int k = 0; k < p; k++)
        if (hist_env[k] > win_peak) win_peak = hist_env[k];
    end
    den = ONE_Q28;
    if (win_peak > UNITY)
      den += longint'(gain_reg) * (longint'(win_peak) - UNITY);
    res.i = shrink(hist_i[r], den);
    res.q = shrink(hist_q[r], den);
    wr_pos = (w == 0) ? p - 1 : w - 1;
    rd_pos = (r == 0) ? p - 1 : r - 1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t wr_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.data  = data;
    row.si    = '0;
    row.sq    = '0;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t smp_row(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq);
    plan_row_t row;
    row      = wr_row(CFG_ENABLE, '0);
    row.kind = ROW_SAMPLE;
    row.si   = si;
    row.sq   = sq;
    return row;
  endfunction

  // sample row whose output can be written down directly
  function automatic plan_row_t known_row(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq,
                                          logic [SMP_W-1:0] ei, logic [SMP_W-1:0] eq);
    plan_row_t row;
    row        = smp_row(si, sq);
    row.known  = 1'b1;
    row.want.i = ei;
    row.want.q = eq;
    return row;
  endfunction

  function automatic logic [SMP_W-1:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // many quiet samples so the window can empty out, with full-scale
  // samples, samples around 1.0 and corners to push the peak up and down
  function automatic iq_t draw_sample();
    int unsigned sel;
    iq_t         s;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      s.i = $urandom_range(0, 24000) - 12000;
      s.q = $urandom_range(0, 24000) - 12000;
    end else if (sel < 75) begin
      s = $urandom;
    end else if (sel < 90) begin
      s.i = 16384 + $urandom_range(0, 600) - 300;
      s.q = $urandom_range(0, 400) - 200;
      if ($urandom_range(0, 1)) s.i = -s.i;
    end else begin
      s.i = corner_val();
      s.q = corner_val();
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all changes at the falling edge
  // ---------------------------------------------------------------------------

  // present one request, hold it until taken, then log what it should produce
  task automatic push_sample(input logic [SMP_W-1:0] si, input logic [SMP_W-1:0] sq,
                             input bit known, input iq_t given);
    iq_t calc;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_i     <= si;
    in_q     <= sq;
    do @(posedge clk); while (in_stall);
    calc = limit_sample(si, sq);
    due_iq.push_back(known ? given : calc);
    @(negedge clk);
  endtask

  // stop sending and hold off until every owed sample is out
  task automatic settle();
    in_valid <= 1'b0;
    while (due_iq.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    note_cfg(idx, data);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // clock, watchdog, output side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // far beyond the slowest legal run: long rescans and heavy stalls
  initial begin
    #36000000;
    $display("FAIL");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // output check against the oldest owed sample
  always @(posedge clk) begin : out_check
    iq_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_iq.size() == 0) begin
        bad_count++;
        $display("%0t unexpected output: expected none, actual i=%0d q=%0d",
                 $time, out_i, out_q);
      end else begin
        want = due_iq.pop_front();
        if (out_i !== want.i) begin
          bad_count++;
          $display("%0t out_i mismatch: expected %0d, actual %0d", $time, want.i, out_i);
        end
        if (out_q !== want.q) begin
          bad_count++;
          $display("%0t out_q mismatch: expected %0d, actual %0d", $time, want.q, out_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    iq_t                   s;
    logic [CFG_DATA_W-1:0] gain_val;
    int unsigned           wsel;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_i      = '0;
    in_q      = '0;
    out_stall = 1'b0;
    bad_count = 0;
    snd_idle  = 35;
    rcv_idle  = 64;

    // model copy of the reset state
    run_en   = 1'b0;
    gain_reg = GAIN_RESET;
    wlen_reg = WLEN_RESET;
    wipe_history();

    // disabled after reset: plain pass-through
    plan.push_back(known_row(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768));
    plan.push_back(known_row(-16'sd1, 16'sd0, -16'sd1, 16'sd0));
    // full gain, window 0 rounds up to 3, then switch on
    plan.push_back(wr_row(CFG_GAIN, 16'hFFFF));
    plan.push_back(wr_row(CFG_WINDOW, 16'd0));
    plan.push_back(wr_row(CFG_ENABLE, 16'd1));
    // half-window delay: the first output reads the cleared line
    plan.push_back(known_row(16'sd32767, 16'sd32767, 16'sd0, 16'sd0));
    plan.push_back(smp_row(16'sd100, 16'sd0));
    plan.push_back(smp_row(16'sd200, -16'sd200));
    // full-scale peak drops out of the window here, forcing a rescan
    plan.push_back(smp_row(16'sd300, 16'sd0));
    // envelope exactly at 1.0 does not scale
    plan.push_back(smp_row(16'sd16384, 16'sd0));
    plan.push_back(smp_row(16'sd0, -16'sd32768));
    // write to an index with no register behind it: no effect at all
    plan.push_back(wr_row(CFG_SPARE, 16'hFFFF));
    plan.push_back(smp_row(-16'sd32768, 16'sd0));
    // zero gain leaves the history and makes the divisor exactly 1.0
    plan.push_back(wr_row(CFG_GAIN, 16'd0));
    plan.push_back(smp_row(-16'sd32768, -16'sd32768));
    plan.push_back(smp_row(16'sd1, 16'sd1));
    // even window 62 rounds to 63, longest delay
    plan.push_back(wr_row(CFG_WINDOW, 16'd62));
    plan.push_back(known_row(16'sd32767, -16'sd32767, 16'sd0, 16'sd0));
    plan.push_back(known_row(-16'sd5, 16'sd7, 16'sd0, 16'sd0));
    // even window 4 rounds to 5
    plan.push_back(wr_row(CFG_GAIN, 16'd16384));
    plan.push_back(wr_row(CFG_WINDOW, 16'd4));
    plan.push_back(known_row(16'sd0, 16'sd0, 16'sd0, 16'sd0));
    plan.push_back(known_row(16'sd12000, -16'sd12000, 16'sd0, 16'sd0));
    plan.push_back(smp_row(-16'sd20000, 16'sd30000));
    plan.push_back(smp_row(16'sd32767, 16'sd32767));
    // switching off clears the lines and passes samples straight on
    plan.push_back(wr_row(CFG_ENABLE, 16'd0));
    plan.push_back(known_row(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[n].idx, plan[n].data);
      end else begin
        push_sample(plan[n].si, plan[n].sq, plan[n].known, plan[n].want);
      end
    end

    // random streams: receiver-heavy idling, then sender-heavy, then none
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 5)
        0:       begin snd_idle = 35; rcv_idle = 64; end
        1:       begin snd_idle = 64; rcv_idle = 35; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase
      // the block has to be idle before any register changes
      settle();
      case (seg % 5)
        0:       gain_val = 16'hFFFF;
        1:       gain_val = 16'h0000;
        2:       gain_val = 16'd16384;
        default: gain_val = $urandom;
      endcase
      if (seg % 4 == 1) begin
        // gain change alone: the window history carries over
        write_reg(CFG_GAIN, gain_val);
      end else begin
        wsel = (seg % 3 == 0) ? 3 : (seg % 3 == 1) ? 63 : $urandom_range(0, 63);
        // upper data bits are don't-care for the narrow registers
        write_reg(CFG_WINDOW, {$urandom_range(0, 1023), wsel[WLEN_W-1:0]});
        write_reg(CFG_GAIN, gain_val);
        write_reg(CFG_ENABLE, {$urandom_range(0, 32767), (seg % 6 != 4)});
      end
      if (seg % 7 == 5) write_reg(CFG_SPARE, $urandom);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        s = draw_sample();
        push_sample(s.i, s.q, 1'b0, '0);
      end
    end

    // drain, then leave room for anything stray to show up
    settle();
    repeat (DRAIN_TICKS) @(negedge clk);
    if (bad_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/eol_pkg.sv
rtl/eol_ram.sv
rtl/envelope_overshoot_limiter.sv
tb/sv/envelope_overshoot_limiter_tb.sv
